// ===== rtl/dmt_pkg.sv =====
// dmt_pkg: shared widths, register indexes, control word type and width helpers
// for the disk Mobius translation pipeline. Depends on nothing.
`default_nettype none

package dmt_pkg;

  // Fixed field widths
  localparam int Z_W   = 18;
  localparam int A_W   = 17;
  localparam int OUT_W = 19;
  localparam int IDX_W = 2;

  localparam int FRAC_BITS_DEF = 16;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_AMOUNT_RE = 2'd0;
  localparam logic [IDX_W-1:0] REG_AMOUNT_IM = 2'd1;

  // Quotient bits kept by the dividers (twice the output scale, for rounding)
  localparam int QUO_W   = OUT_W + 1;
  // Divider latency: magnitude, range check, one stage per bit, round/saturate
  localparam int DIV_LAT = QUO_W + 3;

  // Control word carried along the pipe
  typedef struct packed {
    logic valid;
    logic fault;
  } ctl_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Sum of two z*a products plus rounding constant
  function automatic int pw(input int q);
    return imax(Z_W + A_W, q + 1) + 1;
  endfunction

  // Denominator parts
  function automatic int dw(input int q);
    return imax(pw(q) - q, q + 2) + 1;
  endfunction

  // |a|^2 plus rounding constant
  function automatic int saw(input int q);
    return imax(2 * A_W, q + 1) + 1;
  endfunction

  // 1 - |a|^2
  function automatic int dfw(input int q);
    return imax(saw(q) - q, q + 2) + 1;
  endfunction

  // Squared denominator terms before rounding
  function automatic int sqw(input int q);
    return 2 * dw(q) + 2;
  endfunction

  // Clamped squared denominator parts
  function automatic int srw(input int q);
    return (q + 7 >= 31) ? 32 : q + 9;
  endfunction

  function automatic int numw(input int q);
    return Z_W + 1 + dw(q) + 1;
  endfunction

  function automatic int mw(input int q);
    return 2 * dw(q);
  endfunction

  function automatic int m2w(input int q);
    return 2 * srw(q);
  endfunction

  function automatic int snw(input int q);
    return dfw(q) + srw(q) + 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/disk_mobius_translation.sv =====
// disk_mobius_translation: top level. Amount registers, front pipeline, four
// dividers and the result register. Depends on dmt_pkg, dmt_front, dmt_div.
//
//  channel   signals                               direction  handshake
//  command   start, busy, z_re, z_im               in         start & !busy
//  result    done, image_re/im, speed_re/im,       out        done, one cycle
//            div_fault
//  config    cfg_we, cfg_index, cfg_data           in         cfg_we
//
// One point enters every cycle; busy is always low. From start to done a point
// passes the front multiplier stages, the one-bit-per-stage dividers and the
// result register. Reset clears the amount registers and all valid bits. The
// receiver takes each result in its done cycle.
`default_nettype none

module disk_mobius_translation #(
  parameter int FRAC_BITS = dmt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [dmt_pkg::Z_W-1:0]    z_re,
  input  wire logic signed [dmt_pkg::Z_W-1:0]    z_im,
  input  wire logic                              cfg_we,
  input  wire logic [dmt_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [dmt_pkg::A_W-1:0]           cfg_data,
  output logic                                   done,
  output logic signed [dmt_pkg::OUT_W-1:0]       image_re,
  output logic signed [dmt_pkg::OUT_W-1:0]       image_im,
  output logic signed [dmt_pkg::OUT_W-1:0]       speed_re,
  output logic signed [dmt_pkg::OUT_W-1:0]       speed_im,
  output logic                                   div_fault
);
  import dmt_pkg::*;

  localparam int NUMW = numw(FRAC_BITS);
  localparam int MW   = mw(FRAC_BITS);
  localparam int M2W  = m2w(FRAC_BITS);
  localparam int SNW  = snw(FRAC_BITS);

  logic signed [A_W-1:0]  amount_re, amount_im;
  ctl_t                   f_ctl;
  logic signed [NUMW-1:0] f_num_re, f_num_im;
  logic [MW-1:0]          f_norm;
  logic signed [SNW-1:0]  f_sn_re, f_sn_im;
  logic [M2W-1:0]         f_norm2;
  logic signed [OUT_W-1:0] q_ire, q_iim, q_sre, q_sim;
  ctl_t                   ctl_d [DIV_LAT+1];

  assign busy = 1'b0;

  // Amount registers
  always_ff @(posedge clk) begin
    if (rst) begin
      amount_re <= '0;
      amount_im <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AMOUNT_RE: amount_re <= cfg_data;
        REG_AMOUNT_IM: amount_im <= cfg_data;
        default: ;
      endcase
    end
  end

  dmt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .z_re     (z_re),
    .z_im     (z_im),
    .a_re     (amount_re),
    .a_im     (amount_im),
    .ctl      (f_ctl),
    .num_re   (f_num_re),
    .num_im   (f_num_im),
    .norm     (f_norm),
    .sn_re    (f_sn_re),
    .sn_im    (f_sn_im),
    .norm2    (f_norm2)
  );

  dmt_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUMW), .DEN_W(MW)) u_div_ire (
    .clk (clk), .num (f_num_re), .den (f_norm), .quo (q_ire)
  );

  dmt_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUMW), .DEN_W(MW)) u_div_iim (
    .clk (clk), .num (f_num_im), .den (f_norm), .quo (q_iim)
  );

  dmt_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(SNW), .DEN_W(M2W)) u_div_sre (
    .clk (clk), .num (f_sn_re), .den (f_norm2), .quo (q_sre)
  );

  dmt_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(SNW), .DEN_W(M2W)) u_div_sim (
    .clk (clk), .num (f_sn_im), .den (f_norm2), .quo (q_sim)
  );

  // Control word follows the dividers
  assign ctl_d[0] = f_ctl;

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_d[k+1] <= '0;
      end else begin
        ctl_d[k+1] <= ctl_d[k];
      end
    end
  end

  // Result register, zero on a faulted denominator
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_d[DIV_LAT].valid;
    end
  end

  always_ff @(posedge clk) begin
    div_fault <= ctl_d[DIV_LAT].fault;
    image_re  <= ctl_d[DIV_LAT].fault ? '0 : q_ire;
    image_im  <= ctl_d[DIV_LAT].fault ? '0 : q_iim;
    speed_re  <= ctl_d[DIV_LAT].fault ? '0 : q_sre;
    speed_im  <= ctl_d[DIV_LAT].fault ? '0 : q_sim;
  end

endmodule

`default_nettype wire

// ===== rtl/dmt_front.sv =====
// dmt_front: seven-stage front end. Forms the denominator, numerators, the
// denominator norms and derivative terms for the dividers; uses dmt_pkg.
`default_nettype none

module dmt_front #(
  parameter int FRAC_BITS = dmt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        in_valid,
  input  wire logic signed [dmt_pkg::Z_W-1:0]              z_re,
  input  wire logic signed [dmt_pkg::Z_W-1:0]              z_im,
  input  wire logic signed [dmt_pkg::A_W-1:0]              a_re,
  input  wire logic signed [dmt_pkg::A_W-1:0]              a_im,
  output dmt_pkg::ctl_t                                    ctl,
  output logic signed [dmt_pkg::numw(FRAC_BITS)-1:0]       num_re,
  output logic signed [dmt_pkg::numw(FRAC_BITS)-1:0]       num_im,
  output logic        [dmt_pkg::mw(FRAC_BITS)-1:0]         norm,
  output logic signed [dmt_pkg::snw(FRAC_BITS)-1:0]        sn_re,
  output logic signed [dmt_pkg::snw(FRAC_BITS)-1:0]        sn_im,
  output logic        [dmt_pkg::m2w(FRAC_BITS)-1:0]        norm2
);
  import dmt_pkg::*;

  localparam int Q    = FRAC_BITS;
  localparam int ZA   = Z_W + A_W;
  localparam int AA   = 2 * A_W;
  localparam int PW   = pw(Q);
  localparam int DW   = dw(Q);
  localparam int SAW  = saw(Q);
  localparam int DFW  = dfw(Q);
  localparam int SQW  = sqw(Q);
  localparam int RW   = SQW - Q;
  localparam int SRW  = srw(Q);
  localparam int NRW  = Z_W + 1;
  localparam int NPW  = NRW + DW;
  localparam int NUMW = numw(Q);
  localparam int MW   = mw(Q);
  localparam int SNW  = snw(Q);

  localparam logic signed [PW-1:0]  HALF_P = PW'(1) <<< (Q - 1);
  localparam logic signed [SAW-1:0] HALF_S = SAW'(1) <<< (Q - 1);
  localparam logic signed [SQW-1:0] HALF_Q = SQW'(1) <<< (Q - 1);
  localparam logic signed [DW-1:0]  ONE_D  = DW'(1) <<< Q;
  localparam logic signed [DFW-1:0] ONE_F  = DFW'(1) <<< Q;
  localparam longint                LIM_I  = (Q + 7 >= 31) ? 64'sh7FFF_FFFF
                                                           : (64'sd1 <<< (Q + 7));
  localparam logic signed [RW-1:0]  LIM_R  = RW'(LIM_I);
  localparam logic signed [RW-1:0]  NLIM_R = -RW'(LIM_I);

  // Stage valid and fault flags
  logic v1, v2, v3, v4, v5, v6, v7;
  logic f4, f5, f6, f7;

  // S1: captured point and amount
  logic signed [Z_W-1:0] zr1, zi1;
  logic signed [A_W-1:0] ar1, ai1;

  // S2: cross products and numerator sums
  logic signed [ZA-1:0]  p_ra2, p_ib2, p_ia2, p_rb2;
  logic signed [AA-1:0]  p_aa2, p_bb2;
  logic signed [NRW-1:0] nr2, ni2;

  // S3: denominator and 1 - |a|^2
  logic signed [DW-1:0]  dr3, di3;
  logic signed [DFW-1:0] diff3;
  logic signed [NRW-1:0] nr3, ni3;
  logic signed [PW-1:0]  s_re, s_im;
  logic signed [SAW-1:0] s_aa;

  // S4: squares and numerator products
  logic signed [2*DW-1:0] dr2_4, di2_4, drdi4;
  logic signed [NPW-1:0]  nrdr4, nidi4, nidr4, nrdi4;
  logic signed [DFW-1:0]  diff4;

  // S5: norm, numerators, clamped square of the denominator
  logic [MW-1:0]          m5;
  logic signed [NUMW-1:0] nre5, nim5;
  logic signed [SRW-1:0]  sr5, si5;
  logic signed [DFW-1:0]  diff5;
  logic signed [SQW-1:0]  sq_re, sq_im;
  logic signed [RW-1:0]   rr_re, rr_im;

  // S6: products of the squared denominator
  logic signed [2*SRW-1:0]    sr2_6, si2_6;
  logic signed [DFW+SRW-1:0]  dsr6, dsi6;
  logic [MW-1:0]              m6;
  logic signed [NUMW-1:0]     nre6, nim6;
  logic signed [DFW-1:0]      diff6;
  logic                       tiny6;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  // S1
  always_ff @(posedge clk) begin
    zr1 <= z_re;
    zi1 <= z_im;
    ar1 <= a_re;
    ai1 <= a_im;
  end

  // S2
  always_ff @(posedge clk) begin
    p_ra2 <= zr1 * ar1;
    p_ib2 <= zi1 * ai1;
    p_ia2 <= zi1 * ar1;
    p_rb2 <= zr1 * ai1;
    p_aa2 <= ar1 * ar1;
    p_bb2 <= ai1 * ai1;
    nr2   <= NRW'(zr1) + NRW'(ar1);
    ni2   <= NRW'(zi1) + NRW'(ai1);
  end

  // S3: round half up is an arithmetic shift after adding half
  assign s_re = PW'(p_ra2) + PW'(p_ib2) + HALF_P;
  assign s_im = PW'(p_ia2) - PW'(p_rb2) + HALF_P;
  assign s_aa = SAW'(p_aa2) + SAW'(p_bb2) + HALF_S;

  always_ff @(posedge clk) begin
    dr3   <= ONE_D + DW'(s_re >>> Q);
    di3   <= DW'(s_im >>> Q);
    diff3 <= ONE_F - DFW'(s_aa >>> Q);
    nr3   <= nr2;
    ni3   <= ni2;
  end

  // S4
  always_ff @(posedge clk) begin
    dr2_4 <= dr3 * dr3;
    di2_4 <= di3 * di3;
    drdi4 <= dr3 * di3;
    nrdr4 <= nr3 * dr3;
    nidi4 <= ni3 * di3;
    nidr4 <= ni3 * dr3;
    nrdi4 <= nr3 * di3;
    diff4 <= diff3;
    f4    <= (dr3 == '0) && (di3 == '0);
  end

  // S5
  assign sq_re = SQW'(dr2_4) - SQW'(di2_4) + HALF_Q;
  assign sq_im = (SQW'(drdi4) <<< 1) + HALF_Q;
  assign rr_re = RW'(sq_re >>> Q);
  assign rr_im = RW'(sq_im >>> Q);

  always_ff @(posedge clk) begin
    m5    <= $unsigned(dr2_4) + $unsigned(di2_4);
    nre5  <= NUMW'(nrdr4) + NUMW'(nidi4);
    nim5  <= NUMW'(nidr4) - NUMW'(nrdi4);
    sr5   <= (rr_re > LIM_R) ? SRW'(LIM_R) : (rr_re < NLIM_R) ? SRW'(NLIM_R) : SRW'(rr_re);
    si5   <= (rr_im > LIM_R) ? SRW'(LIM_R) : (rr_im < NLIM_R) ? SRW'(NLIM_R) : SRW'(rr_im);
    diff5 <= diff4;
    f5    <= f4;
  end

  // S6
  always_ff @(posedge clk) begin
    sr2_6 <= sr5 * sr5;
    si2_6 <= si5 * si5;
    dsr6  <= diff5 * sr5;
    dsi6  <= diff5 * si5;
    m6    <= m5;
    nre6  <= nre5;
    nim6  <= nim5;
    diff6 <= diff5;
    tiny6 <= (sr5 == '0) && (si5 == '0);
    f6    <= f5;
  end

  // S7: squared norm and derivative numerators; a vanishing squared
  // denominator passes 1 - |a|^2 so the divider saturates by its sign
  always_ff @(posedge clk) begin
    norm2  <= $unsigned(sr2_6) + $unsigned(si2_6);
    sn_re  <= tiny6 ? SNW'(diff6) : SNW'(dsr6);
    sn_im  <= -SNW'(dsi6);
    norm   <= m6;
    num_re <= nre6;
    num_im <= nim6;
    f7     <= f6;
  end

  assign ctl.valid = v7;
  assign ctl.fault = f7;

endmodule

`default_nettype wire

// ===== rtl/dmt_div.sv =====
// dmt_div: pipelined restoring divider, one quotient bit per stage, giving
// num * 2^FRAC_BITS / den rounded half away from zero and saturated. Uses dmt_pkg.
`default_nettype none

module dmt_div #(
  parameter int FRAC_BITS = dmt_pkg::FRAC_BITS_DEF,
  parameter int NUM_W     = 40,
  parameter int DEN_W     = 40
) (
  input  wire logic                              clk,
  input  wire logic signed [NUM_W-1:0]           num,
  input  wire logic        [DEN_W-1:0]           den,
  output logic signed [dmt_pkg::OUT_W-1:0]       quo
);
  import dmt_pkg::*;

  localparam int XW = NUM_W + FRAC_BITS + 1;
  localparam int CW = imax(XW, DEN_W + QUO_W);
  localparam logic signed [OUT_W-1:0] MAXV = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] MINV = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [QUO_W-1:0] MAX_Q = QUO_W'(MAXV);
  localparam logic [QUO_W-1:0] MIN_Q = QUO_W'(1) << (OUT_W - 1);

  // Stage A: sign and magnitude
  logic             neg_a;
  logic [NUM_W-1:0] u_a;
  logic [DEN_W-1:0] d_a;
  logic [XW-1:0]    x_a;

  // Per-bit stages, index 0 is the range-check stage
  logic [DEN_W-1:0] rem [QUO_W+1];
  logic [QUO_W-1:0] xl  [QUO_W+1];
  logic [QUO_W-1:0] qq  [QUO_W+1];
  logic [DEN_W-1:0] dd  [QUO_W+1];
  logic             ng  [QUO_W+1];
  logic             st  [QUO_W+1];
  logic             zq  [QUO_W+1];

  logic [QUO_W:0]   rsum;
  logic [QUO_W-1:0] rq;

  always_ff @(posedge clk) begin
    neg_a <= num[NUM_W-1];
    u_a   <= $unsigned(num[NUM_W-1] ? -num : num);
    d_a   <= den;
  end

  // Stage B: quotient range check, zero numerator and first partial remainder
  assign x_a = {u_a, {(FRAC_BITS+1){1'b0}}};

  always_ff @(posedge clk) begin
    st[0]  <= (u_a != '0) && (CW'(x_a) >= CW'({d_a, {QUO_W{1'b0}}}));
    zq[0]  <= (u_a == '0);
    rem[0] <= DEN_W'(x_a >> QUO_W);
    xl[0]  <= x_a[QUO_W-1:0];
    qq[0]  <= '0;
    dd[0]  <= d_a;
    ng[0]  <= neg_a;
  end

  // One quotient bit per stage
  for (genvar k = 0; k < QUO_W; k++) begin : g_bit
    logic [DEN_W:0] trial;
    logic           ge;

    assign trial = {rem[k], xl[k][QUO_W-1]};
    assign ge    = trial >= {1'b0, dd[k]};

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? DEN_W'(trial - {1'b0, dd[k]}) : DEN_W'(trial);
      xl[k+1]  <= xl[k] << 1;
      qq[k+1]  <= {qq[k][QUO_W-2:0], ge};
      dd[k+1]  <= dd[k];
      ng[k+1]  <= ng[k];
      st[k+1]  <= st[k];
      zq[k+1]  <= zq[k];
    end
  end

  // Round half up on the doubled quotient, then saturate; zero in, zero out
  assign rsum = {1'b0, qq[QUO_W]} + (QUO_W+1)'(1);
  assign rq   = rsum[QUO_W:1];

  always_ff @(posedge clk) begin
    if (zq[QUO_W]) begin
      quo <= '0;
    end else if (st[QUO_W]) begin
      quo <= ng[QUO_W] ? MINV : MAXV;
    end else if (ng[QUO_W]) begin
      quo <= (rq >= MIN_Q) ? MINV : -OUT_W'(rq);
    end else begin
      quo <= (rq >= MAX_Q) ? MAXV : OUT_W'(rq);
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for disk_mobius_translation.
// It drives fixed-point points under several translation amounts and checks
// each result against a local predictor. Depends on dmt_pkg and the RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [18:0] img_re;
    logic signed [18:0] img_im;
    logic signed [18:0] spd_re;
    logic signed [18:0] spd_im;
    logic               fault;
  } image_word_t;

  typedef struct {
    logic [17:0] re;
    logic [17:0] im;
  } point_t;

  localparam longint ONE_Q = 64'sd65536;
  localparam longint SAT_HI = 262143;
  localparam longint SAT_LO = -262144;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [17:0] z_re = '0;
  logic signed [17:0] z_im = '0;
  logic cfg_we = 1'b0;
  logic [dmt_pkg::IDX_W-1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic done;
  logic signed [18:0] image_re, image_im, speed_re, speed_im;
  logic div_fault;

  // translation amount as the block holds it
  logic [16:0] amt_re = '0;
  logic [16:0] amt_im = '0;

  point_t      pending_points[$];
  image_word_t expected_images[$];
  int          sender_idle_pct = 0;
  int          fail_count = 0;
  int          accepted_points = 0;
  int          checked_images = 0;
  int          fault_images = 0;

  disk_mobius_translation u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .z_re(z_re), .z_im(z_im),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .image_re(image_re), .image_im(image_im), .speed_re(speed_re),
    .speed_im(speed_im), .div_fault(div_fault)
  );

  always #5 clk = ~clk;

  // round half up, Q16
  function automatic longint q16_round(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // num * 2^16 / d, nearest with ties away from zero, saturated
  function automatic longint div_round_sat(input longint num, input longint d);
    logic neg;
    longint u, q, r;
    neg = num < 0;
    u = neg ? -num : num;
    if (u == 0) return 0;
    if (d == 0) return neg ? SAT_LO : SAT_HI;
    q = u / d;
    r = u % d;
    if (q > SAT_HI + 2) return neg ? SAT_LO : SAT_HI;
    for (int i = 0; i < 16; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        q = q + 1;
        r = r - d;
      end
      if (q > SAT_HI + 2) return neg ? SAT_LO : SAT_HI;
    end
    if ((r << 1) >= d) q = q + 1;
    if (neg) return (q >= -SAT_LO) ? SAT_LO : -q;
    return (q >= SAT_HI) ? SAT_HI : q;
  endfunction

  // expected image and derivative of one point
  function automatic image_word_t predict_translation(input logic [16:0] ar_b,
      input logic [16:0] ai_b, input logic [17:0] zr_b, input logic [17:0] zi_b);
    image_word_t w;
    longint ar, ai, zr, zi, dr, di, nr, ni, m, sr, si, diff, m2;
    ar = longint'($signed(ar_b));
    ai = longint'($signed(ai_b));
    zr = longint'($signed(zr_b));
    zi = longint'($signed(zi_b));
    dr = ONE_Q + q16_round(zr * ar + zi * ai);
    di = q16_round(zi * ar - zr * ai);
    w = '{default: '0};
    if (dr == 0 && di == 0) begin
      w.fault = 1'b1;
      return w;
    end
    nr = zr + ar;
    ni = zi + ai;
    m = dr * dr + di * di;
    sr = clamp_sym(q16_round(dr * dr - di * di), 64'sd8388608);
    si = clamp_sym(q16_round(2 * dr * di), 64'sd8388608);
    diff = ONE_Q - q16_round(ar * ar + ai * ai);
    m2 = sr * sr + si * si;
    w.img_re = 19'(div_round_sat(nr * dr + ni * di, m));
    w.img_im = 19'(div_round_sat(ni * dr - nr * di, m));
    if (m2 == 0) begin
      w.spd_re = 19'(div_round_sat(diff, 0));
    end else begin
      w.spd_re = 19'(div_round_sat(diff * sr, m2));
      w.spd_im = 19'(div_round_sat(-(diff * si), m2));
    end
    return w;
  endfunction

  // driver: holds a word while busy, records the expectation on acceptance
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_images.push_back(predict_translation(amt_re, amt_im, z_re, z_im));
        accepted_points++;
      end
      if (!(start && busy)) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          point_t p;
          p = pending_points.pop_front();
          z_re <= p.re;
          z_im <= p.im;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done word is compared with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_images.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        image_word_t e;
        e = expected_images.pop_front();
        checked_images++;
        if (e.fault) fault_images++;
        if (image_re !== e.img_re) begin
          $error("image_re expected %0d got %0d", e.img_re, image_re);
          fail_count++;
        end
        if (image_im !== e.img_im) begin
          $error("image_im expected %0d got %0d", e.img_im, image_im);
          fail_count++;
        end
        if (speed_re !== e.spd_re) begin
          $error("speed_re expected %0d got %0d", e.spd_re, speed_re);
          fail_count++;
        end
        if (speed_im !== e.spd_im) begin
          $error("speed_im expected %0d got %0d", e.spd_im, speed_im);
          fail_count++;
        end
        if (div_fault !== e.fault) begin
          $error("div_fault expected %0b got %0b", e.fault, div_fault);
          fail_count++;
        end
      end
    end
  end

  task automatic add_point(input logic [17:0] re, input logic [17:0] im);
    point_t p;
    p.re = re;
    p.im = im;
    pending_points.push_back(p);
  endtask

  // wait until every queued word has gone through and come back
  task automatic drain();
    @(negedge clk);
    while (pending_points.size() > 0 || start || expected_images.size() > 0)
      @(negedge clk);
  endtask

  task automatic write_amount(input logic [16:0] re, input logic [16:0] im);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= dmt_pkg::REG_AMOUNT_RE;
    cfg_data <= re;
    @(posedge clk);
    cfg_index <= dmt_pkg::REG_AMOUNT_IM;
    cfg_data <= im;
    @(posedge clk);
    cfg_we <= 1'b0;
    amt_re = re;
    amt_im = im;
  endtask

  // mostly points in the closed disk square, some anywhere in the field
  task automatic add_random_points(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        add_point(18'($urandom), 18'($urandom));
      else
        add_point(18'($urandom_range(131072) - 65536), 18'($urandom_range(131072) - 65536));
    end
  endtask

  initial begin
    logic [16:0] set_re[10];
    logic [16:0] set_im[10];
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset amount, extremes of z
    add_point(18'sd0, 18'sd0);
    add_point(18'sd131071, -18'sd131072);
    add_point(-18'sd131072, 18'sd131071);
    add_point(18'sd65536, 18'sd65536);
    add_point(-18'sd65536, 18'sd0);
    add_point(18'h15555, 18'h2AAAA);
    drain();

    // directed: a = 1/2 gives a zero denominator and a tiny one
    write_amount(17'sd32768, 17'sd0);
    add_point(-18'sd131072, 18'sd0);
    add_point(-18'sd131070, 18'sd0);
    add_point(-18'sd131071, 18'sd0);
    add_point(-18'sd131069, 18'sd0);
    add_point(18'sd131071, 18'sd131071);
    add_point(18'sd0, -18'sd131072);
    drain();

    // directed: amount extremes, including the out-of-disk pattern
    write_amount(17'sd65535, -17'sd65535);
    add_point(-18'sd65536, 18'sd65536);
    add_point(18'sd65535, -18'sd65535);
    add_point(18'sd0, 18'sd0);
    drain();
    write_amount(17'h10000, 17'h10000);
    add_point(18'sd65536, 18'sd0);
    add_point(-18'sd131072, -18'sd131072);
    add_point(18'sd131071, 18'sd0);
    drain();

    // random part across amount settings and idle profiles
    set_re = '{17'sd0, 17'sd65535, -17'sd65535, 17'sd32768, 17'h10000, 17'sd0,
               17'($urandom), 17'($urandom_range(90000) - 45000),
               17'($urandom_range(131070) - 65535), -17'sd1};
    set_im = '{17'sd0, 17'sd0, 17'sd65535, -17'sd32768, 17'h1FFFF, -17'sd65535,
               17'($urandom), 17'($urandom_range(90000) - 45000),
               17'($urandom_range(131070) - 65535), 17'sd1};
    for (int s = 0; s < 10; s++) begin
      sender_idle_pct = (s < 3) ? 28 : (s < 6) ? 57 : 0;
      write_amount(set_re[s], set_im[s]);
      add_random_points(135);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_images.size() != 0) begin
      $error("%0d expected words never arrived", expected_images.size());
      fail_count++;
    end
    $display("covered %0d points under 14 amount settings, %0d words checked",
             accepted_points, checked_images);
    $display("zero-denominator words seen: %0d, mismatches: %0d",
             fault_images, fail_count);
    if (fail_count == 0) begin
      $display("PASS disk_mobius_translation");
    end else begin
      $display("FAIL disk_mobius_translation");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAIL disk_mobius_translation");
    $finish;
  end

endmodule

`default_nettype wire
